// ===== design/mbg_pkg.sv =====
`timescale 1ns / 1ps
package mbg_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CARVED  = 2'd0,
    ST_DONE    = 2'd1,
    ST_READ    = 2'd2,
    ST_STARTED = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_TOP,
    S_TOPW,
    S_NBR,
    S_NBRW,
    S_PICK,
    S_DIV,
    S_CARVE1,
    S_CARVE2,
    S_READ1,
    S_READ2,
    S_OUT
  } state_t;

  localparam logic [3:0] WALL_N = 4'd1;
  localparam logic [3:0] WALL_E = 4'd2;
  localparam logic [3:0] WALL_S = 4'd4;
  localparam logic [3:0] WALL_W = 4'd8;

  function automatic logic [3:0] near_side(input logic [1:0] d);
    case (d)
      2'd0: near_side = WALL_N;
      2'd1: near_side = WALL_S;
      2'd2: near_side = WALL_W;
      default: near_side = WALL_E;
    endcase
  endfunction

  function automatic logic [3:0] far_side(input logic [1:0] d);
    case (d)
      2'd0: far_side = WALL_S;
      2'd1: far_side = WALL_N;
      2'd2: far_side = WALL_E;
      default: far_side = WALL_W;
    endcase
  endfunction

endpackage

// ===== design/mbg_ram.sv =====
`timescale 1ns / 1ps
module mbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/mbg_mod.sv =====
`timescale 1ns / 1ps
module mbg_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [2:0]  divisor,
  output logic        busy,
  output logic [1:0]  rem
);
  logic [1:0] acc;
  logic [31:0] sh;
  logic [2:0] cnt;
  logic [2:0] div;
  logic [1:0] low;
  logic [1:0] acc_next;

  // Since 256 is 1 mod 3, the bytes of the word are folded in one per cycle.
  always_comb begin
    logic [3:0] t;
    t = 4'(acc) + 4'(sh[1:0]) + 4'(sh[3:2]) + 4'(sh[5:4]) + 4'(sh[7:6]);
    if (t >= 4'd9) t = t - 4'd9;
    if (t >= 4'd6) t = t - 4'd6;
    if (t >= 4'd3) t = t - 4'd3;
    acc_next = t[1:0];
  end

  always_comb begin
    case (div)
      3'd2: rem = {1'b0, low[0]};
      3'd3: rem = acc;
      3'd4: rem = low;
      default: rem = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt <= 3'd4;
      acc <= '0;
      sh <= dividend;
      div <= divisor;
      low <= dividend[1:0];
    end else if (busy) begin
      sh <= {8'd0, sh[31:8]};
      acc <= acc_next;
      cnt <= cnt - 3'd1;
      if (cnt == 3'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ===== design/maze_backtracker_generator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake      Fields
// cfg       in         valid/ready    cfg_data (difficulty)
// in        in         valid/stall    command, random_word, query_row, query_col
// out       out        valid/stall    status, from_row, from_col, direction, wall_bits
// A start sweeps every storage row once before its result is ready.
// A step that carves reads the stack top, checks the neighbours, picks one and carves;
// each dead end is popped and retried; an empty stack gives done. Reads use S_READ1, S_READ2.
// The result waits in its register while out_stall is high, and the next item can be taken
// once the block is back in idle after the result leaves.
// Reset is synchronous; the block takes no item while busy or while a result waits.
module maze_backtracker_generator #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int MAX_CELLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] random_word,
  input  logic [3:0]  query_row,
  input  logic [3:0]  query_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  from_row,
  output logic [3:0]  from_col,
  output logic [1:0]  direction,
  output logic [3:0]  wall_bits
);
  import mbg_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int DW = $clog2(MAX_CELLS + 1);

  state_t state, state_next;
  logic [1:0] difficulty;
  logic [4:0] grid_rows, grid_cols;
  logic [DW-1:0] depth;
  logic [AW-1:0] sweep;
  logic [31:0] rnd;
  logic [3:0] qr, qc;
  logic [AW-1:0] top;
  logic [1:0] nidx;
  logic [3:0] cand;
  logic [2:0] ncount;
  logic [1:0] dir;
  logic [1:0] ctr;

  logic w_we, v_we, p_we;
  logic [AW-1:0] w_waddr, w_raddr, v_waddr, v_raddr, p_waddr, p_raddr;
  logic [3:0] w_wdata, w_rdata;
  logic v_wdata, v_rdata;
  logic [AW-1:0] p_wdata, p_rdata;

  mbg_ram #(.WIDTH(4), .DEPTH(MAX_CELLS)) u_walls (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata));
  mbg_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_vis (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata));
  mbg_ram #(.WIDTH(AW), .DEPTH(MAX_CELLS)) u_stack (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata));

  logic mod_go, mod_busy;
  logic [1:0] mod_rem;
  mbg_mod u_mod (.clk, .rst, .go(mod_go), .dividend(rnd), .divisor(ncount),
    .busy(mod_busy), .rem(mod_rem));

  logic [31:0] top_r, top_c;
  assign top_r = 32'(top) / MAX_COLS;
  assign top_c = 32'(top) % MAX_COLS;

  logic signed [7:0] nr, nc;
  logic n_ok;
  always_comb begin
    nr = 8'(signed'({1'b0, top_r[6:0]}));
    nc = 8'(signed'({1'b0, top_c[6:0]}));
    case (nidx)
      2'd0: nr = nr - 8'sd1;
      2'd1: nr = nr + 8'sd1;
      2'd2: nc = nc - 8'sd1;
      default: nc = nc + 8'sd1;
    endcase
    n_ok = (nr >= 0) && (nc >= 0) && (nr < 8'(signed'({3'b0, grid_rows})))
      && (nc < 8'(signed'({3'b0, grid_cols})))
      && (32'(nr) * MAX_COLS + 32'(nc) < MAX_CELLS);
  end
  logic [AW-1:0] naddr;
  assign naddr = AW'(32'(nr) * MAX_COLS + 32'(nc));

  // Neighbor validity is registered with its index so it lines up with the visited read.
  logic pend_ok;
  logic [1:0] pend_idx;
  logic pend_v;
  logic nbr_free;
  assign nbr_free = pend_v && pend_ok && !v_rdata;

  logic [1:0] pick;
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    pick = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (k == mod_rem) pick = 2'(i);
        k = k + 2'd1;
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  logic take;
  assign take = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (take) begin
        case (command)
          CMD_START: state_next = S_CLEAR;
          CMD_STEP: state_next = S_TOP;
          CMD_READ: state_next = S_READ1;
          default: state_next = S_IDLE;
        endcase
      end
      S_CLEAR: if (sweep == AW'(MAX_CELLS - 1)) state_next = S_OUT;
      S_TOP: state_next = (depth == '0) ? S_OUT : S_TOPW;
      S_TOPW: state_next = S_NBR;
      S_NBR: if (ctr == 2'd3) state_next = S_NBRW;
      S_NBRW: state_next = S_PICK;
      S_PICK: state_next = (ncount == 3'd0) ? S_TOP : S_DIV;
      S_DIV: if (!mod_busy && !mod_go) state_next = S_CARVE1;
      S_CARVE1: state_next = S_CARVE2;
      S_CARVE2: state_next = S_OUT;
      S_READ1: state_next = S_READ2;
      S_READ2: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic sweep_in;
  always_comb begin
    logic [31:0] sr, sc;
    sr = 32'(sweep) / MAX_COLS;
    sc = 32'(sweep) % MAX_COLS;
    sweep_in = (sr < 32'(grid_rows)) && (sc < 32'(grid_cols));
  end

  logic [AW-1:0] here;
  assign here = top;
  logic [AW-1:0] there;
  always_comb begin
    logic signed [7:0] r2, c2;
    r2 = 8'(signed'({1'b0, top_r[6:0]}));
    c2 = 8'(signed'({1'b0, top_c[6:0]}));
    case (dir)
      2'd0: r2 = r2 - 8'sd1;
      2'd1: r2 = r2 + 8'sd1;
      2'd2: c2 = c2 - 8'sd1;
      default: c2 = c2 + 8'sd1;
    endcase
    there = AW'(32'(r2) * MAX_COLS + 32'(c2));
  end

  always_comb begin
    w_we = 1'b0; w_waddr = sweep; w_wdata = 4'hF; w_raddr = here;
    v_we = 1'b0; v_waddr = sweep; v_wdata = 1'b0; v_raddr = naddr;
    p_we = 1'b0; p_waddr = AW'(depth); p_wdata = there; p_raddr = AW'(depth - DW'(1));
    mod_go = 1'b0;
    case (state)
      S_CLEAR: begin
        v_we = 1'b1;
        v_wdata = (sweep == '0);
        w_we = sweep_in;
        p_we = (sweep == '0);
        p_waddr = '0;
        p_wdata = '0;
      end
      S_PICK: mod_go = (ncount != 3'd0);
      S_DIV: w_raddr = here;
      S_CARVE1: begin
        w_we = 1'b1; w_waddr = here; w_wdata = w_rdata & ~near_side(dir);
        w_raddr = there;
        v_we = 1'b1; v_waddr = there; v_wdata = 1'b1;
        p_we = (depth < DW'(MAX_CELLS));
      end
      S_CARVE2: begin
        w_we = 1'b1; w_waddr = there; w_wdata = w_rdata & ~far_side(dir);
      end
      S_READ1: w_raddr = AW'(32'(qr) * MAX_COLS + 32'(qc));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      difficulty <= 2'd0;
      grid_rows <= 5'd6;
      grid_cols <= 5'd8;
      depth <= '0;
      sweep <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) difficulty <= cfg_data;
      if (state_next == S_OUT && state != S_OUT) out_valid <= 1'b1;
      if (state == S_OUT && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (take) begin
          rnd <= random_word; qr <= query_row; qc <= query_col;
          status <= ST_STARTED; from_row <= '0; from_col <= '0;
          direction <= '0; wall_bits <= '0; sweep <= '0;
          if (command == CMD_START) begin
            case (difficulty)
              2'd0: begin
                grid_rows <= 5'(MAX_ROWS < 6 ? MAX_ROWS : 6);
                grid_cols <= 5'(MAX_COLS < 8 ? MAX_COLS : 8);
              end
              2'd1: begin
                grid_rows <= 5'(MAX_ROWS < 9 ? MAX_ROWS : 9);
                grid_cols <= 5'(MAX_COLS < 12 ? MAX_COLS : 12);
              end
              default: begin
                grid_rows <= 5'(MAX_ROWS < 12 ? MAX_ROWS : 12);
                grid_cols <= 5'(MAX_COLS < 16 ? MAX_COLS : 16);
              end
            endcase
          end
        end
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(MAX_CELLS - 1)) depth <= DW'(1);
        end
        S_TOP: begin
          if (depth == '0) status <= ST_DONE;
        end
        S_TOPW: begin
          top <= p_rdata; nidx <= 2'd0; ctr <= 2'd0; cand <= '0; ncount <= '0;
        end
        S_NBR: begin
          // The visited read of the previous neighbor returns this cycle.
          ctr <= ctr + 2'd1;
          nidx <= nidx + 2'd1;
          if (nbr_free) begin
            cand[pend_idx] <= 1'b1;
            ncount <= ncount + 3'd1;
          end
        end
        S_NBRW: begin
          if (nbr_free) begin
            cand[pend_idx] <= 1'b1;
            ncount <= ncount + 3'd1;
          end
        end
        S_PICK: if (ncount == 3'd0) depth <= depth - DW'(1);
        S_CARVE1: begin
          if (depth < DW'(MAX_CELLS)) depth <= depth + DW'(1);
          status <= ST_CARVED;
          from_row <= top_r[3:0]; from_col <= top_c[3:0]; direction <= dir;
        end
        S_DIV: dir <= pick;
        S_READ2: begin
          status <= ST_READ; from_row <= qr; from_col <= qc;
          wall_bits <= ({1'b0, qr} < grid_rows && {1'b0, qc} < grid_cols
            && 32'(qr) * MAX_COLS + 32'(qc) < MAX_CELLS) ? w_rdata : 4'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else begin
      pend_v <= (state == S_NBR);
      pend_ok <= n_ok;
      pend_idx <= nidx;
    end
  end
endmodule

// ===== design/mbg_checker.sv =====
`timescale 1ns / 1ps
module mbg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [1:0] direction,
  input logic [3:0] wall_bits
);
  import mbg_pkg::*;

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DONE || status == ST_STARTED)
    |-> wall_bits == 4'd0 && direction == 2'd0)
    else $error("done or started carries data");
  a_carve: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CARVED |-> wall_bits == 4'd0) else $error("carve carries walls");
endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .status, .direction, .wall_bits);
